// ===== design/mmc_pkg.sv =====
// Shared constants and types for the min-max contrast to byte converter.
package mmc_pkg;

   localparam int SAMPLE_BITS_DEF   = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF   = 4;

   typedef struct packed {
      logic signed_mode;
      logic always_scale;
   } cfg_type;

endpackage

// ===== design/mmc_queue.sv =====
// Small first-in first-out queue between the front and back ends.
module mmc_queue #(
   parameter int WIDTH = 96,
   parameter int DEPTH = mmc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/mmc_front.sv =====
// Front end: accepts samples, tracks running min and max, queues convert samples.
module mmc_front #(
   parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_kind,
   input  logic                   in_frame_start,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   output logic                   in_stall,
   input  logic                   queue_full,
   output logic                   push,
   output logic [SAMPLE_BITS-1:0] push_sample,
   output logic [SAMPLE_BITS-1:0] push_min,
   output logic [SAMPLE_BITS-1:0] push_max
);

   logic                   accept;
   logic [SAMPLE_BITS-1:0] min_ff;
   logic [SAMPLE_BITS-1:0] max_ff;
   logic [SAMPLE_BITS-1:0] min_in;
   logic [SAMPLE_BITS-1:0] max_in;

   assign in_stall    = queue_full;
   assign accept      = in_valid && !queue_full;
   assign push        = accept && in_kind;
   assign push_sample = in_sample;
   assign push_min    = min_ff;
   assign push_max    = max_ff;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (accept && !in_kind) begin
         if (in_frame_start) begin
            min_in = in_sample;
            max_in = in_sample;
         end else begin
            if ($signed(in_sample) < $signed(min_ff)) begin
               min_in = in_sample;
            end
            if ($signed(in_sample) > $signed(max_ff)) begin
               max_in = in_sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         max_ff <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

endmodule

// ===== design/mmc_back.sv =====
// Back end: picks the mapping rule, divides with rounding, holds the result register.
module mmc_back #(
   parameter int SAMPLE_BITS   = mmc_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = mmc_pkg::FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mmc_pkg::cfg_type       cfg,
   input  logic                   q_empty,
   input  logic [SAMPLE_BITS-1:0] q_sample,
   input  logic [SAMPLE_BITS-1:0] q_min,
   input  logic [SAMPLE_BITS-1:0] q_max,
   output logic                   q_pop,
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic [7:0]             out_gray,
   output logic                   out_flat
);

   localparam int DW = (SAMPLE_BITS > FRACTION_BITS) ? SAMPLE_BITS + 1 : FRACTION_BITS + 1;
   localparam int NW = DW + 8;
   localparam logic signed [63:0] NOSCALE_LIMIT = 64'sd255 <<< FRACTION_BITS;
   localparam logic [3:0] STEP_SAT = 4'd8;
   localparam logic [7:0] GRAY_MAX = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAG,
      ST_PREP,
      ST_SCALE,
      ST_DIV,
      ST_ROUND,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic                   out_valid_ff;
   logic [7:0]             out_gray_ff;
   logic                   out_flat_ff;
   logic [SAMPLE_BITS-1:0] s_ff;
   logic [SAMPLE_BITS-1:0] min_ff;
   logic [SAMPLE_BITS-1:0] max_ff;
   logic [DW-1:0]          mag_ff;
   logic                   noscale_ff;
   logic                   range_ok_ff;
   logic [DW-1:0]          t_ff;
   logic [DW-1:0]          d_ff;
   logic                   mul_ff;
   logic [NW-1:0]          rem_ff;
   logic [NW-1:0]          ds_ff;
   logic [3:0]             step_ff;
   logic [7:0]             q_ff;
   logic [7:0]             res_gray_ff;
   logic                   res_flat_ff;

   logic signed [DW:0] s_wide;
   logic signed [DW:0] min_wide;
   logic signed [DW:0] max_wide;
   logic [DW-1:0]      mag_min;
   logic [DW-1:0]      mag_max;
   logic signed [DW:0] t_signed;
   logic signed [DW:0] t_stretch;
   logic signed [DW:0] range_wide;
   logic               ge;
   logic [DW:0]        twice_rem;
   logic               round_up;
   logic [DW-1:0]      prep_t;
   logic [DW-1:0]      prep_d;
   logic               prep_mul;
   logic               prep_flat;
   logic               prep_skip;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign out_valid = out_valid_ff;
   assign out_gray  = out_gray_ff;
   assign out_flat  = out_flat_ff;

   always_comb begin
      s_wide     = (DW+1)'($signed(s_ff));
      min_wide   = (DW+1)'($signed(min_ff));
      max_wide   = (DW+1)'($signed(max_ff));
      mag_min    = min_ff[SAMPLE_BITS-1] ? DW'(-min_wide) : DW'(min_wide);
      mag_max    = max_ff[SAMPLE_BITS-1] ? DW'(-max_wide) : DW'(max_wide);
      t_signed   = $signed({1'b0, mag_ff}) + s_wide;
      t_stretch  = s_wide - min_wide;
      range_wide = max_wide - min_wide;
      ge         = (rem_ff >= ds_ff);
      twice_rem  = {rem_ff[DW-1:0], 1'b0};
      round_up   = (twice_rem > {1'b0, d_ff}) || ((twice_rem == {1'b0, d_ff}) && q_ff[0]);
   end

   // rule selection: numerator, divisor, and the zero-range and nonpositive shortcuts
   always_comb begin
      if (cfg.signed_mode) begin
         prep_t    = t_signed[DW-1:0];
         prep_d    = {mag_ff[DW-2:0], 1'b0};
         prep_mul  = 1'b1;
         prep_flat = (mag_ff == '0);
         prep_skip = t_signed[DW] || (t_signed == '0);
      end else if (noscale_ff) begin
         prep_t    = DW'(s_wide);
         prep_d    = DW'(1) << FRACTION_BITS;
         prep_mul  = 1'b0;
         prep_flat = 1'b0;
         prep_skip = s_wide[DW] || (s_wide == '0);
      end else begin
         prep_t    = t_stretch[DW-1:0];
         prep_d    = range_wide[DW-1:0];
         prep_mul  = 1'b1;
         prep_flat = !range_ok_ff;
         prep_skip = t_stretch[DW] || (t_stretch == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && (!out_valid_ff || !out_stall)) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && !out_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  s_ff     <= q_sample;
                  min_ff   <= q_min;
                  max_ff   <= q_max;
                  state_ff <= ST_MAG;
               end
            end
            ST_MAG: begin
               mag_ff      <= (mag_max > mag_min) ? mag_max : mag_min;
               noscale_ff  <= !cfg.always_scale && (64'($signed(max_ff)) <= NOSCALE_LIMIT);
               range_ok_ff <= ($signed(max_ff) > $signed(min_ff));
               state_ff    <= ST_PREP;
            end
            ST_PREP: begin
               t_ff        <= prep_t;
               d_ff        <= prep_d;
               mul_ff      <= prep_mul;
               res_gray_ff <= '0;
               res_flat_ff <= prep_flat;
               state_ff    <= (prep_flat || prep_skip) ? ST_DONE : ST_SCALE;
            end
            ST_SCALE: begin
               // times 255 as shift and subtract
               rem_ff   <= mul_ff ? ({t_ff, 8'b0} - NW'(t_ff)) : NW'(t_ff);
               ds_ff    <= {d_ff, 8'b0};
               step_ff  <= STEP_SAT;
               q_ff     <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               ds_ff <= ds_ff >> 1;
               if (step_ff == STEP_SAT) begin
                  // quotient of 256 or more saturates
                  if (ge) begin
                     res_gray_ff <= GRAY_MAX;
                     state_ff    <= ST_DONE;
                  end
                  step_ff <= step_ff - 1'b1;
               end else begin
                  if (ge) begin
                     rem_ff <= rem_ff - ds_ff;
                  end
                  q_ff <= {q_ff[6:0], ge};
                  if (step_ff == '0) begin
                     state_ff <= ST_ROUND;
                  end else begin
                     step_ff <= step_ff - 1'b1;
                  end
               end
            end
            ST_ROUND: begin
               res_gray_ff <= (q_ff == GRAY_MAX) ? GRAY_MAX : q_ff + 8'(round_up);
               state_ff    <= ST_DONE;
            end
            ST_DONE: begin
               if (!out_valid_ff || !out_stall) begin
                  out_gray_ff  <= res_gray_ff;
                  out_flat_ff  <= res_flat_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/minmax_contrast_to_byte.sv =====
// Top level of the min-max contrast to byte converter.
//
// Usage: a frame is sent twice on the req_ channel. Measure samples
// (req_kind 0) update the running minimum and maximum; req_frame_start
// restarts both at that sample. Convert samples (req_kind 1) each give one
// rsp_ transfer with an 8-bit gray level and a flat flag; measure samples
// give none. The csr_ port holds signed_mode (address 0) and always_scale
// (address 4); write them only while the block is idle.
// Measure samples transfer one per cycle while req_stall is low. A convert
// sample goes through a QUEUE_DEPTH-entry queue (four by default) to the back
// end, which takes it through MAG, PREP, SCALE, DIV (a restoring divider),
// ROUND and DONE; that back end sets the rate of convert samples. Zero-range
// and below-range samples go from PREP to DONE; saturated ones leave DIV early.
// Reset clears the queue, rsp_valid and both registers, and sets
// the minimum to the largest and the maximum to the smallest sample value.
// When rsp_stall is high the result holds; the back end finishes its next
// sample and waits, and the front stalls req_ only once the queue is full.
module minmax_contrast_to_byte #(
   parameter int SAMPLE_BITS   = mmc_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = mmc_pkg::FRACTION_BITS_DEF,
   parameter int QUEUE_DEPTH   = mmc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic                   req_frame_start,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_gray,
   output logic                   rsp_flat,
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam logic REG_SIGNED_MODE  = 1'b0;
   localparam logic REG_ALWAYS_SCALE = 1'b1;
   localparam int   QW = 3 * SAMPLE_BITS;

   mmc_pkg::cfg_type cfg_ff;
   mmc_pkg::cfg_type cfg_in;
   logic             csr_write;

   logic                   q_push;
   logic                   q_pop;
   logic                   q_full;
   logic                   q_empty;
   logic [SAMPLE_BITS-1:0] push_sample;
   logic [SAMPLE_BITS-1:0] push_min;
   logic [SAMPLE_BITS-1:0] push_max;
   logic [QW-1:0]          pop_data;

   // Register writes complete in the access phase; pready is never held low.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_SIGNED_MODE:  cfg_in.signed_mode  = csr_pwdata[0];
            REG_ALWAYS_SCALE: cfg_in.always_scale = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SIGNED_MODE:  csr_prdata = {31'b0, cfg_ff.signed_mode};
         REG_ALWAYS_SCALE: csr_prdata = {31'b0, cfg_ff.always_scale};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept, track min and max, queue convert samples with their range.
   mmc_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_kind        (req_kind),
      .in_frame_start (req_frame_start),
      .in_sample      (req_sample),
      .in_stall       (req_stall),
      .queue_full     (q_full),
      .push           (q_push),
      .push_sample    (push_sample),
      .push_min       (push_min),
      .push_max       (push_max)
   );

   mmc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_sample, push_min, push_max}),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: map one queued sample at a time and drive the result register.
   mmc_back #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_sample  (pop_data[QW-1 -: SAMPLE_BITS]),
      .q_min     (pop_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS]),
      .q_max     (pop_data[SAMPLE_BITS-1:0]),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_gray  (rsp_gray),
      .out_flat  (rsp_flat)
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_measure_no_push: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_kind) |-> !q_push)
      else $error("measure sample entered the queue");

   a_flat_is_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flat) |-> (rsp_gray == 8'd0))
      else $error("flat result with nonzero gray");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue pop while empty");
`endif

endmodule
